// ----- rtl/core/leb_pkg.sv -----
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the LEB128 varint decoder: the input and
// result word layouts, byte field positions and result status codes.
// ----------------------------------------------------------------------------
package leb_pkg;

  // Accumulator width and bit positions
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned SHIFT_STEP = 7;
  localparam int unsigned LAST_SHIFT = 63;

  // Byte fields
  localparam int unsigned CONT_POS = 7;
  localparam int unsigned SIGN_POS = 6;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // One encoded byte plus the number's mode (sampled on its first byte)
  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
  } in_t;

  // One decoded number
  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 status;
  } out_t;

endpackage

// ----- rtl/core/leb128_varint_decoder.sv -----
// ----------------------------------------------------------------------------
// leb128_varint_decoder
// Streaming 64-bit LEB128 decoder: one encoded byte per word in, one decoded
// number (or an overflow error) per word out.
// ----------------------------------------------------------------------------
// The block takes one byte every cycle unless input ready is low, and keeps
// taking continuation bytes while a finished number waits at the output. A
// byte is registered at the input and folded into the accumulator on the
// edge that it advances; that edge also loads the output register with any
// number that the byte ends. Continuation bytes give no result. The mode
// bit is sampled on the first byte of each number. A number ends after at
// most ten bytes; a tenth byte above one gives an error word (value zero,
// status overflow) and the decoder starts afresh. Outside reset, input
// ready drops only while the output register holds a word that is not
// taken and the registered byte would produce another one.
// ----------------------------------------------------------------------------
module leb128_varint_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  leb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output leb_pkg::out_t out_data
);

  localparam int unsigned WB = leb_pkg::WORD_BITS;
  localparam int unsigned SW = leb_pkg::SHIFT_W;

  // Input register
  logic         s1_valid_r;
  leb_pkg::in_t s1_data_r;

  // Decoder state
  logic [WB-1:0] acc_r;
  logic [SW-1:0] shift_r;
  logic          signed_r;

  // Output register
  logic          out_valid_r;
  leb_pkg::out_t out_data_r;

  // Per-byte decode
  logic          first_byte;
  logic          sgn;
  logic          ovf;
  logic          done;
  logic          emits;
  logic          s1_fire;
  logic [SW:0]   next_shift;
  logic [WB-1:0] payload;
  logic [WB-1:0] acc_nxt;
  logic [WB-1:0] ext_mask;
  logic [WB-1:0] value_nxt;

  always_comb begin
    first_byte = (shift_r == '0);
    sgn        = first_byte ? s1_data_r.mode : signed_r;
    ovf        = (shift_r == SW'(leb_pkg::LAST_SHIFT)) && (s1_data_r.data_byte > 8'd1);
    done       = !s1_data_r.data_byte[leb_pkg::CONT_POS];
    emits      = ovf || done;
    next_shift = {1'b0, shift_r} + (SW+1)'(leb_pkg::SHIFT_STEP);
    payload    = {{(WB-7){1'b0}}, s1_data_r.data_byte[6:0]} << shift_r;
    acc_nxt    = acc_r | payload;
    ext_mask   = {WB{1'b1}} << next_shift[SW-1:0];
    value_nxt  = acc_nxt;
    // Sign-extend above the last payload group while it still fits
    if (sgn && !next_shift[SW] && s1_data_r.data_byte[leb_pkg::SIGN_POS]) begin
      value_nxt = acc_nxt | ext_mask;
    end
    if (ovf) begin
      value_nxt = '0;
    end
  end

  // Advance the registered byte unless its result would overwrite a waiting word
  assign s1_fire  = s1_valid_r && (!emits || !out_valid_r || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || s1_fire);

  // Capture the incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Fold the byte into the accumulator; clear at the end of a number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      shift_r  <= '0;
      signed_r <= 1'b0;
    end else if (s1_fire) begin
      if (emits) begin
        acc_r    <= '0;
        shift_r  <= '0;
        signed_r <= 1'b0;
      end else begin
        acc_r    <= acc_nxt;
        shift_r  <= next_shift[SW-1:0];
        signed_r <= sgn;
      end
    end
  end

  // Load or drain the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emits) begin
      out_data_r.value  <= value_nxt;
      out_data_r.status <= ovf ? leb_pkg::STATUS_OVERFLOW : leb_pkg::STATUS_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/leb_checker.sv -----
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks for the LEB128 varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input leb_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input leb_pkg::out_t out_data
);

  // No result word survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // An error word carries a zero value
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == leb_pkg::STATUS_OVERFLOW) |-> out_data.value == '0)
    else $error("overflow word with nonzero value");

  // A fresh result follows an accepted input byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted byte");

  // No byte is taken during reset
  a_no_accept_reset: assert property (@(posedge clk) !rst_n |-> !in_ready)
    else $error("input ready during reset");

endmodule

bind leb128_varint_decoder leb_checker u_leb_checker (.*);
